@@ rtl/core/hpg_pkg.sv @@
// Shared constants, types and the prime base table for the Halton point generator.
`timescale 1ns / 1ps

package hpg_pkg;

    // Sizing of the generator.
    localparam int MAX_DIMENSIONS = 8;
    localparam int INDEX_BITS     = 32;
    localparam int FRACTION_BITS  = 32;

    // The shared divider word must hold either an index or a fraction.
    localparam int WORD_BITS = (INDEX_BITS > FRACTION_BITS) ? INDEX_BITS : FRACTION_BITS;

    // Bases go up to the 32nd prime (131), so eight bits cover every digit and base.
    localparam int BASE_BITS        = 8;
    localparam int PRIME_INDEX_BITS = 5;

    // Component numbering and the dimension clamp.
    localparam int COMPONENT_BITS   = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;
    localparam int ACTIVE_DIM_BITS  = 4;
    localparam int DIM_BITS         = $clog2(MAX_DIMENSIONS + 1);
    localparam int DIM_CMP_BITS     = (DIM_BITS > ACTIVE_DIM_BITS) ? DIM_BITS : ACTIVE_DIM_BITS;

    // Sequencer counters.
    localparam int STEP_BITS        = $clog2(WORD_BITS);
    localparam int DIGIT_CNT_BITS   = $clog2(INDEX_BITS + 1);
    localparam int DIGIT_ADDR_BITS  = $clog2(INDEX_BITS);

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVE_DIMENSIONS = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_INDEX     = 2'd1;

    // Control of the shared divide step unit.
    typedef struct packed {
        logic load;
        logic step;
    } hpg_div_ctrl_t;

    // The i-th prime, used as the base of component i.
    function automatic logic [BASE_BITS-1:0] prime_base(input logic [PRIME_INDEX_BITS-1:0] idx);
        logic [BASE_BITS-1:0] p;
        case (idx)
            5'd0:    p = 8'd2;
            5'd1:    p = 8'd3;
            5'd2:    p = 8'd5;
            5'd3:    p = 8'd7;
            5'd4:    p = 8'd11;
            5'd5:    p = 8'd13;
            5'd6:    p = 8'd17;
            5'd7:    p = 8'd19;
            5'd8:    p = 8'd23;
            5'd9:    p = 8'd29;
            5'd10:   p = 8'd31;
            5'd11:   p = 8'd37;
            5'd12:   p = 8'd41;
            5'd13:   p = 8'd43;
            5'd14:   p = 8'd47;
            5'd15:   p = 8'd53;
            5'd16:   p = 8'd59;
            5'd17:   p = 8'd61;
            5'd18:   p = 8'd67;
            5'd19:   p = 8'd71;
            5'd20:   p = 8'd73;
            5'd21:   p = 8'd79;
            5'd22:   p = 8'd83;
            5'd23:   p = 8'd89;
            5'd24:   p = 8'd97;
            5'd25:   p = 8'd101;
            5'd26:   p = 8'd103;
            5'd27:   p = 8'd107;
            5'd28:   p = 8'd109;
            5'd29:   p = 8'd113;
            5'd30:   p = 8'd127;
            5'd31:   p = 8'd131;
            default: p = 8'd2;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/core/hpg_divider.sv @@
// Bit-serial restoring divide step unit shared by digit extraction and fraction building.
`timescale 1ns / 1ps

module hpg_divider
    import hpg_pkg::*;
(
    input  logic                 clk,
    input  hpg_div_ctrl_t        ctrl,
    input  logic [WORD_BITS-1:0] load_word,
    input  logic [BASE_BITS-1:0] load_rem,
    input  logic [BASE_BITS-1:0] base,
    output logic [WORD_BITS-1:0] word,
    output logic [BASE_BITS-1:0] rem
);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic [BASE_BITS-1:0] rem_reg;
    logic [BASE_BITS-1:0] rem_next;
    logic [BASE_BITS:0]   shifted;
    logic [BASE_BITS:0]   diff;
    logic                 fits;

    // One step: bring down the top bit of the word, subtract the base where it fits,
    // and shift the quotient bit in at the bottom of the word.
    always_comb
    begin
        shifted   = {rem_reg, word_reg[WORD_BITS-1]};
        fits      = (shifted >= {1'b0, base});
        diff      = shifted - {1'b0, base};
        word_next = word_reg;
        rem_next  = rem_reg;
        if (ctrl.load)
        begin
            word_next = load_word;
            rem_next  = load_rem;
        end
        else if (ctrl.step)
        begin
            word_next = {word_reg[WORD_BITS-2:0], fits};
            rem_next  = fits ? diff[BASE_BITS-1:0] : shifted[BASE_BITS-1:0];
        end
    end

    // Working registers carry payload only and need no reset.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        rem_reg  <= rem_next;
    end

    assign word = word_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/core/halton_point_generator.sv @@
// Top level of the Halton point generator: sequencer, digit store and result register.
`timescale 1ns / 1ps

// Each accepted request with next_point set yields one result per active dimension, the
// radical inverse of the current index in the bases 2, 3, 5, 7 and so on, as a truncated
// Q0.32 fraction; the index then steps by one and wraps. All arithmetic runs through one
// bit-serial divide unit that retires one bit per cycle. For each component the index is
// taken apart into its digits in that base, one full division per digit, and the digits
// are then folded back into the fraction, most significant first, one full division per
// digit; index zero skips both. Larger bases have fewer digits and so take less work.
// The request channel is ready only between points. A finished result waits in its own
// output register while the next component is worked out. Writing register 1 reloads
// the index counter; a request with next_point clear yields nothing.

module halton_point_generator
    import hpg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      request_valid,
    output logic                      request_ready,
    input  logic                      next_point,
    output logic                      result_valid,
    input  logic                      result_ready,
    output logic [COMPONENT_BITS-1:0] component,
    output logic [FRACTION_BITS-1:0]  coordinate,
    output logic [INDEX_BITS-1:0]     point_index,
    output logic                      last_component
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_EXTRACT,
        ST_EXT_DONE,
        ST_ACC_NEXT,
        ST_ACCUM,
        ST_ACC_DONE,
        ST_EMIT
    } state_t;

    state_t                     state_reg,              state_next;
    logic [ACTIVE_DIM_BITS-1:0] active_dimensions_reg,  active_dimensions_next;
    logic [INDEX_BITS-1:0]      index_counter_reg,      index_counter_next;
    logic [INDEX_BITS-1:0]      work_index_reg,         work_index_next;
    logic [COMPONENT_BITS-1:0]  dims_last_reg,          dims_last_next;
    logic [COMPONENT_BITS-1:0]  comp_reg,               comp_next;
    logic [STEP_BITS-1:0]       step_reg,               step_next;
    logic [DIGIT_CNT_BITS-1:0]  digit_cnt_reg,          digit_cnt_next;
    logic [FRACTION_BITS-1:0]   acc_reg,                acc_next;
    logic                       result_valid_reg,       result_valid_next;
    logic [COMPONENT_BITS-1:0]  component_reg,          component_next;
    logic [FRACTION_BITS-1:0]   coordinate_reg,         coordinate_next;
    logic [INDEX_BITS-1:0]      point_index_reg,        point_index_next;
    logic                       last_component_reg,     last_component_next;

    logic [BASE_BITS-1:0]       digits_reg [INDEX_BITS];
    logic                       digit_we;
    logic [DIGIT_ADDR_BITS-1:0] digit_wr_addr;
    logic [DIGIT_CNT_BITS-1:0]  digit_cnt_dec;
    logic [DIGIT_ADDR_BITS-1:0] digit_rd_addr;

    hpg_div_ctrl_t              div_ctrl;
    logic [WORD_BITS-1:0]       div_load_word;
    logic [BASE_BITS-1:0]       div_load_rem;
    logic [WORD_BITS-1:0]       div_word;
    logic [BASE_BITS-1:0]       div_rem;
    logic [BASE_BITS-1:0]       base;
    logic [INDEX_BITS-1:0]      quotient;
    logic [DIM_CMP_BITS-1:0]    dims_clamped;
    logic                       is_last;

    // Base of the component under work and the quotient left by the last extraction.
    assign base     = prime_base(PRIME_INDEX_BITS'(comp_reg));
    assign quotient = div_word[INDEX_BITS-1:0];
    assign is_last  = (comp_reg == dims_last_reg);

    // Digit store addressing: write at the fill count, read the most significant left.
    assign digit_wr_addr = digit_cnt_reg[DIGIT_ADDR_BITS-1:0];
    assign digit_cnt_dec = digit_cnt_reg - 1'b1;
    assign digit_rd_addr = digit_cnt_dec[DIGIT_ADDR_BITS-1:0];

    // Zero dimensions acts as one and anything above the maximum acts as the maximum.
    always_comb
    begin
        dims_clamped = DIM_CMP_BITS'(active_dimensions_reg);
        if (dims_clamped == '0)
        begin
            dims_clamped = DIM_CMP_BITS'(1);
        end
        else if (dims_clamped > DIM_CMP_BITS'(MAX_DIMENSIONS))
        begin
            dims_clamped = DIM_CMP_BITS'(MAX_DIMENSIONS);
        end
    end

    hpg_divider u_divider (
        .clk       (clk),
        .ctrl      (div_ctrl),
        .load_word (div_load_word),
        .load_rem  (div_load_rem),
        .base      (base),
        .word      (div_word),
        .rem       (div_rem)
    );

    // Sequencer: take the index apart into digits, then fold them back into a fraction.
    always_comb
    begin
        state_next             = state_reg;
        active_dimensions_next = active_dimensions_reg;
        index_counter_next     = index_counter_reg;
        work_index_next        = work_index_reg;
        dims_last_next         = dims_last_reg;
        comp_next              = comp_reg;
        step_next              = step_reg;
        digit_cnt_next         = digit_cnt_reg;
        acc_next               = acc_reg;
        result_valid_next      = result_valid_reg;
        component_next         = component_reg;
        coordinate_next        = coordinate_reg;
        point_index_next       = point_index_reg;
        last_component_next    = last_component_reg;
        div_ctrl               = '0;
        div_load_word          = '0;
        div_load_rem           = '0;
        digit_we               = 1'b0;
        request_ready          = (state_reg == ST_IDLE);

        // Configuration writes; unknown register indexes are ignored.
        if (cfg_we)
        begin
            if (cfg_index == CFG_ACTIVE_DIMENSIONS)
            begin
                active_dimensions_next = cfg_data[ACTIVE_DIM_BITS-1:0];
            end
            else if (cfg_index == CFG_INITIAL_INDEX)
            begin
                index_counter_next = INDEX_BITS'(cfg_data);
            end
        end

        // The output register empties when its transaction completes.
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (request_valid && next_point)
                begin
                    work_index_next    = index_counter_reg;
                    index_counter_next = index_counter_reg + 1'b1;
                    dims_last_next     = COMPONENT_BITS'(dims_clamped - 1'b1);
                    comp_next          = '0;
                    state_next         = ST_START;
                end
            end

            ST_START:
            begin
                digit_cnt_next = '0;
                acc_next       = '0;
                if (work_index_reg == '0)
                begin
                    state_next = ST_ACC_NEXT;
                end
                else
                begin
                    div_ctrl.load = 1'b1;
                    div_load_word = WORD_BITS'(work_index_reg) << (WORD_BITS - INDEX_BITS);
                    step_next     = '0;
                    state_next    = ST_EXTRACT;
                end
            end

            ST_EXTRACT:
            begin
                div_ctrl.step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(INDEX_BITS - 1))
                begin
                    state_next = ST_EXT_DONE;
                end
            end

            ST_EXT_DONE:
            begin
                // The remainder is the next digit; carry on while the quotient is non-zero.
                digit_we       = 1'b1;
                digit_cnt_next = digit_cnt_reg + 1'b1;
                if (quotient == '0)
                begin
                    state_next = ST_ACC_NEXT;
                end
                else
                begin
                    div_ctrl.load = 1'b1;
                    div_load_word = WORD_BITS'(quotient) << (WORD_BITS - INDEX_BITS);
                    step_next     = '0;
                    state_next    = ST_EXTRACT;
                end
            end

            ST_ACC_NEXT:
            begin
                if (digit_cnt_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    // Divide (digit * 2^F + fraction) by the base, one bit per cycle.
                    div_ctrl.load  = 1'b1;
                    div_load_word  = WORD_BITS'(acc_reg) << (WORD_BITS - FRACTION_BITS);
                    div_load_rem   = digits_reg[digit_rd_addr];
                    digit_cnt_next = digit_cnt_dec;
                    step_next      = '0;
                    state_next     = ST_ACCUM;
                end
            end

            ST_ACCUM:
            begin
                div_ctrl.step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(FRACTION_BITS - 1))
                begin
                    state_next = ST_ACC_DONE;
                end
            end

            ST_ACC_DONE:
            begin
                acc_next   = div_word[FRACTION_BITS-1:0];
                state_next = ST_ACC_NEXT;
            end

            ST_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next   = 1'b1;
                    component_next      = comp_reg;
                    coordinate_next     = acc_reg;
                    point_index_next    = work_index_reg;
                    last_component_next = is_last;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            active_dimensions_reg <= ACTIVE_DIM_BITS'(1);
            index_counter_reg     <= INDEX_BITS'(1);
            work_index_reg        <= '0;
            dims_last_reg         <= '0;
            comp_reg              <= '0;
            step_reg              <= '0;
            digit_cnt_reg         <= '0;
            acc_reg               <= '0;
            result_valid_reg      <= 1'b0;
            component_reg         <= '0;
            coordinate_reg        <= '0;
            point_index_reg       <= '0;
            last_component_reg    <= 1'b0;
        end
        else
        begin
            state_reg             <= state_next;
            active_dimensions_reg <= active_dimensions_next;
            index_counter_reg     <= index_counter_next;
            work_index_reg        <= work_index_next;
            dims_last_reg         <= dims_last_next;
            comp_reg              <= comp_next;
            step_reg              <= step_next;
            digit_cnt_reg         <= digit_cnt_next;
            acc_reg               <= acc_next;
            result_valid_reg      <= result_valid_next;
            component_reg         <= component_next;
            coordinate_reg        <= coordinate_next;
            point_index_reg       <= point_index_next;
            last_component_reg    <= last_component_next;
        end
    end

    // Digit store, least significant digit first.
    always_ff @(posedge clk)
    begin
        if (digit_we)
        begin
            digits_reg[digit_wr_addr] <= div_rem;
        end
    end

    assign result_valid   = result_valid_reg;
    assign component      = component_reg;
    assign coordinate     = coordinate_reg;
    assign point_index    = point_index_reg;
    assign last_component = last_component_reg;

    // A request for a point moves the index counter on by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (request_valid && request_ready && next_point && !cfg_we)
        |=> (index_counter_reg == $past(index_counter_reg) + 1'b1))
        else $error("index counter did not step after a point request");

    // A new result appears only out of the emit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result register loaded outside the emit step");

    // The divider remainder stays below the base while it is stepping.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXTRACT || state_reg == ST_ACCUM) |-> (div_rem < base))
        else $error("divider remainder not below the base");

    // The digit store never holds more digits than the index has bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        digit_cnt_reg <= DIGIT_CNT_BITS'(INDEX_BITS))
        else $error("digit count beyond the digit store");

endmodule
